// ===== hw/rtl/ihb_pkg.sv =====
// Shared types and constants for the IPv4 header builder.
// No dependencies; every other file refers to this package by scoped names.
package ihb_pkg;

  localparam int unsigned ADDR_W      = 32;
  localparam int unsigned WORD_W      = 16;
  localparam int unsigned IDX_W       = 4;
  localparam int unsigned PROTO_W     = 8;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned HDR_WORDS   = 10;
  localparam int unsigned HDR_BYTES   = 20;
  localparam int unsigned MAX_PAYLOAD = 1480;
  localparam int unsigned QDEPTH      = 2;
  localparam int unsigned QPTR_W      = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned QCNT_W      = $clog2(QDEPTH + 1);
  localparam int unsigned SUM_W       = WORD_W + 3;  // seven 16-bit terms

  localparam logic [7:0]        VER_IHL    = 8'h45;
  localparam logic [7:0]        TTL_VALUE  = 8'd64;
  localparam logic [ADDR_W-1:0] BCAST_ADDR = 32'hFFFF_FFFF;
  localparam logic [IDX_W-1:0]  LAST_IDX   = IDX_W'(HDR_WORDS - 1);

  // Header word positions, word 0 first
  localparam logic [IDX_W-1:0] W_VER_TOS = 4'd0;
  localparam logic [IDX_W-1:0] W_TOT_LEN = 4'd1;
  localparam logic [IDX_W-1:0] W_ID      = 4'd2;
  localparam logic [IDX_W-1:0] W_FLAGS   = 4'd3;
  localparam logic [IDX_W-1:0] W_TTL_PRO = 4'd4;
  localparam logic [IDX_W-1:0] W_CSUM    = 4'd5;
  localparam logic [IDX_W-1:0] W_SRC_HI  = 4'd6;
  localparam logic [IDX_W-1:0] W_SRC_LO  = 4'd7;
  localparam logic [IDX_W-1:0] W_DST_HI  = 4'd8;
  localparam logic [IDX_W-1:0] W_DST_LO  = 4'd9;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LOCAL_ADDR = 2'd0,
    REG_SUBNET     = 2'd1,
    REG_GATEWAY    = 2'd2
  } cfg_reg_e;

  // One classified request, as queued between front and back
  typedef struct packed {
    logic [ADDR_W-1:0]  src;
    logic [ADDR_W-1:0]  dst;
    logic [PROTO_W-1:0] proto;
    logic [WORD_W-1:0]  ip_len;
    logic [WORD_W-1:0]  csum;
    logic [ADDR_W-1:0]  next_hop;
    logic               bcast;
    logic               too_long;
  } desc_t;

  // Handshake between a producer and the queue, or the queue and a consumer
  typedef struct packed {
    logic  valid;
    desc_t desc;
  } desc_beat_t;

endpackage

// ===== hw/rtl/ihb_front.sv =====
// Front end: holds the configuration registers, accepts requests and
// classifies them (length check, checksum, next hop). Uses ihb_pkg.
module ihb_front (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [ihb_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [ihb_pkg::ADDR_W-1:0]      cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [ihb_pkg::ADDR_W-1:0]      source_address_i,
  input  logic [ihb_pkg::ADDR_W-1:0]      destination_address_i,
  input  logic [ihb_pkg::PROTO_W-1:0]     protocol_number_i,
  input  logic [ihb_pkg::WORD_W-1:0]      payload_length_i,
  output ihb_pkg::desc_beat_t             push_o,
  input  logic                            push_ready_i
);

  logic [ihb_pkg::ADDR_W-1:0]  local_q, mask_q, gateway_q;
  logic                        valid_q;
  logic [ihb_pkg::ADDR_W-1:0]  src_q, dst_q;
  logic [ihb_pkg::PROTO_W-1:0] proto_q;
  logic [ihb_pkg::WORD_W-1:0]  plen_q;

  logic                        accept;
  logic                        push_fire;
  logic [ihb_pkg::WORD_W-1:0]  ip_len;
  logic [ihb_pkg::WORD_W-1:0]  ttl_proto;
  logic [ihb_pkg::SUM_W-1:0]   sum;
  logic [ihb_pkg::WORD_W:0]    fold1;
  logic [ihb_pkg::WORD_W-1:0]  fold2;
  logic                        on_subnet;
  ihb_pkg::desc_t              desc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      local_q   <= '0;
      mask_q    <= '0;
      gateway_q <= '0;
    end else if (cfg_we_i) begin
      case (ihb_pkg::cfg_reg_e'(cfg_index_i))
        ihb_pkg::REG_LOCAL_ADDR: local_q   <= cfg_data_i;
        ihb_pkg::REG_SUBNET:     mask_q    <= cfg_data_i;
        ihb_pkg::REG_GATEWAY:    gateway_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign push_fire  = valid_q && push_ready_i;
  assign in_ready_o = !valid_q || push_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (accept) begin
      valid_q <= 1'b1;
    end else if (push_fire) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      src_q   <= source_address_i;
      dst_q   <= destination_address_i;
      proto_q <= protocol_number_i;
      plen_q  <= payload_length_i;
    end
  end

  // Checksum over the nine fixed/variable words; id, flags and TOS are zero
  always_comb begin
    ip_len    = plen_q + ihb_pkg::WORD_W'(ihb_pkg::HDR_BYTES);
    ttl_proto = {ihb_pkg::TTL_VALUE, proto_q};
    sum = ihb_pkg::SUM_W'({ihb_pkg::VER_IHL, 8'h00})
        + ihb_pkg::SUM_W'(ip_len)
        + ihb_pkg::SUM_W'(ttl_proto)
        + ihb_pkg::SUM_W'(src_q[31:16]) + ihb_pkg::SUM_W'(src_q[15:0])
        + ihb_pkg::SUM_W'(dst_q[31:16]) + ihb_pkg::SUM_W'(dst_q[15:0]);
    fold1 = (ihb_pkg::WORD_W+1)'(sum[ihb_pkg::WORD_W-1:0])
          + (ihb_pkg::WORD_W+1)'(sum[ihb_pkg::SUM_W-1:ihb_pkg::WORD_W]);
    // second fold cannot carry again
    fold2 = fold1[ihb_pkg::WORD_W-1:0] + ihb_pkg::WORD_W'(fold1[ihb_pkg::WORD_W]);
    on_subnet = (dst_q & mask_q) == (local_q & mask_q);

    desc           = '0;
    desc.too_long  = plen_q > ihb_pkg::WORD_W'(ihb_pkg::MAX_PAYLOAD);
    if (!desc.too_long) begin
      desc.src       = src_q;
      desc.dst       = dst_q;
      desc.proto     = proto_q;
      desc.ip_len    = ip_len;
      desc.csum      = ~fold2;
      desc.bcast     = dst_q == ihb_pkg::BCAST_ADDR;
      desc.next_hop  = desc.bcast ? '0 : (on_subnet ? dst_q : gateway_q);
    end
  end

  assign push_o.valid = valid_q;
  assign push_o.desc  = desc;

endmodule

// ===== hw/rtl/ihb_queue.sv =====
// Short FIFO of classified requests between front and back.
// Uses ihb_pkg for the descriptor type and depth.
module ihb_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ihb_pkg::desc_beat_t push_i,
  output logic                push_ready_o,
  output ihb_pkg::desc_beat_t head_o,
  input  logic                pop_i
);

  ihb_pkg::desc_t              mem_q [ihb_pkg::QDEPTH];
  logic [ihb_pkg::QPTR_W-1:0]  wr_ptr_q, rd_ptr_q;
  logic [ihb_pkg::QCNT_W-1:0]  count_q;
  logic                        do_push, do_pop;

  assign push_ready_o = count_q != ihb_pkg::QCNT_W'(ihb_pkg::QDEPTH);
  assign do_push      = push_i.valid && push_ready_o;
  assign do_pop       = pop_i && (count_q != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == ihb_pkg::QPTR_W'(ihb_pkg::QDEPTH - 1)) ? '0
                                                                       : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == ihb_pkg::QPTR_W'(ihb_pkg::QDEPTH - 1)) ? '0
                                                                       : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_i.desc;
    end
  end

  assign head_o.valid = count_q != '0;
  assign head_o.desc  = mem_q[rd_ptr_q];

endmodule

// ===== hw/rtl/ihb_back.sv =====
// Back end: walks the queue head word by word into the output register, or gives
// one too_long beat. Uses ihb_pkg for word positions and the descriptor type.
module ihb_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  ihb_pkg::desc_beat_t         head_i,
  output logic                        pop_o,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [ihb_pkg::WORD_W-1:0]  header_word_o,
  output logic [ihb_pkg::IDX_W-1:0]   word_index_o,
  output logic [ihb_pkg::ADDR_W-1:0]  next_hop_o,
  output logic                        is_broadcast_o,
  output logic                        too_long_o,
  output logic                        last_word_o
);

  logic [ihb_pkg::IDX_W-1:0]  idx_q;
  logic                       out_valid_q;
  logic [ihb_pkg::WORD_W-1:0] word_q;
  logic [ihb_pkg::IDX_W-1:0]  widx_q;
  logic [ihb_pkg::ADDR_W-1:0] hop_q;
  logic                       bcast_q, long_q, last_q;

  logic                       load;
  logic                       last;
  logic [ihb_pkg::WORD_W-1:0] word;
  ihb_pkg::desc_t             d;

  assign d    = head_i.desc;
  assign load = head_i.valid && (!out_valid_q || out_ready_i);
  assign last = d.too_long || (idx_q == ihb_pkg::LAST_IDX);
  assign pop_o = load && last;

  always_comb begin
    case (idx_q)
      ihb_pkg::W_VER_TOS: word = {ihb_pkg::VER_IHL, 8'h00};
      ihb_pkg::W_TOT_LEN: word = d.ip_len;
      ihb_pkg::W_ID:      word = '0;
      ihb_pkg::W_FLAGS:   word = '0;
      ihb_pkg::W_TTL_PRO: word = {ihb_pkg::TTL_VALUE, d.proto};
      ihb_pkg::W_CSUM:    word = d.csum;
      ihb_pkg::W_SRC_HI:  word = d.src[31:16];
      ihb_pkg::W_SRC_LO:  word = d.src[15:0];
      ihb_pkg::W_DST_HI:  word = d.dst[31:16];
      ihb_pkg::W_DST_LO:  word = d.dst[15:0];
      default:            word = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        idx_q <= last ? '0 : idx_q + 1'b1;
      end
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      word_q  <= d.too_long ? '0 : word;
      widx_q  <= d.too_long ? '0 : idx_q;
      hop_q   <= d.next_hop;
      bcast_q <= d.bcast;
      long_q  <= d.too_long;
      last_q  <= last;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign header_word_o  = word_q;
  assign word_index_o   = widx_q;
  assign next_hop_o     = hop_q;
  assign is_broadcast_o = bcast_q;
  assign too_long_o     = long_q;
  assign last_word_o    = last_q;

endmodule

// ===== hw/rtl/ipv4_header_builder.sv =====
// Builds a 20-byte IPv4 header per request and streams it as ten 16-bit words,
// word 0 first, each tagged with its index, the next hop and the broadcast flag;
// a payload over 1480 bytes yields one too_long beat instead. A request costs ten
// output beats (one per cycle while the receiver is ready), since the output register
// holds a single word. An accepted request passes the front register and the queue
// before its first word enters the output register; a two-entry queue lets new requests
// be accepted and classified while earlier headers are still streaming. Configure
// registers only while idle. Depends on ihb_pkg, ihb_front, ihb_queue and ihb_back.
module ipv4_header_builder (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [ihb_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [ihb_pkg::ADDR_W-1:0]      cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [ihb_pkg::ADDR_W-1:0]      source_address_i,
  input  logic [ihb_pkg::ADDR_W-1:0]      destination_address_i,
  input  logic [ihb_pkg::PROTO_W-1:0]     protocol_number_i,
  input  logic [ihb_pkg::WORD_W-1:0]      payload_length_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [ihb_pkg::WORD_W-1:0]      header_word_o,
  output logic [ihb_pkg::IDX_W-1:0]       word_index_o,
  output logic [ihb_pkg::ADDR_W-1:0]      next_hop_o,
  output logic                            is_broadcast_o,
  output logic                            too_long_o,
  output logic                            last_word_o
);

  ihb_pkg::desc_beat_t push;
  ihb_pkg::desc_beat_t head;
  logic                push_ready;
  logic                pop;

  ihb_front u_front (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .cfg_we_i              (cfg_we_i),
    .cfg_index_i           (cfg_index_i),
    .cfg_data_i            (cfg_data_i),
    .in_valid_i            (in_valid_i),
    .in_ready_o            (in_ready_o),
    .source_address_i      (source_address_i),
    .destination_address_i (destination_address_i),
    .protocol_number_i     (protocol_number_i),
    .payload_length_i      (payload_length_i),
    .push_o                (push),
    .push_ready_i          (push_ready)
  );

  ihb_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_ready_o (push_ready),
    .head_o       (head),
    .pop_i        (pop)
  );

  ihb_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .head_i         (head),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .header_word_o  (header_word_o),
    .word_index_o   (word_index_o),
    .next_hop_o     (next_hop_o),
    .is_broadcast_o (is_broadcast_o),
    .too_long_o     (too_long_o),
    .last_word_o    (last_word_o)
  );

`ifndef SYNTH
  // a header beat that is not the last is followed at once by the next word
  a_words_contiguous: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !last_word_o |=>
      out_valid_o && word_index_o == $past(word_index_o) + 1'b1)
    else $error("header words not contiguous");

  a_too_long_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && too_long_o |->
      last_word_o && header_word_o == '0 && word_index_o == '0 && !is_broadcast_o)
    else $error("length error beat malformed");

  a_last_at_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !too_long_o |->
      last_word_o == (word_index_o == ihb_pkg::LAST_IDX))
    else $error("last flag out of place");

  a_bcast_no_hop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && is_broadcast_o |-> next_hop_o == '0)
    else $error("broadcast carries a next hop");
`endif

endmodule

// ===== test/ipv4_header_builder_tb.sv =====
// Self-checking testbench for ipv4_header_builder: a scoreboard class builds the ten
// expected header beats per request, or one too_long beat; plain tasks drive requests
// and routing writes. Depends on ihb_pkg and the ipv4_header_builder RTL.
`timescale 1ns / 1ps

module ipv4_header_builder_tb;

  // no register here, write ignored
  localparam logic [ihb_pkg::CFG_IDX_W-1:0] REG_UNMAPPED = 2'd3;
  localparam int unsigned SETTLE_CYCLES = 4;

  typedef struct packed {
    logic [ihb_pkg::WORD_W-1:0] word;
    logic [ihb_pkg::IDX_W-1:0]  index;
    logic [ihb_pkg::ADDR_W-1:0] hop;
    logic                       bcast;
    logic                       too_long;
    logic                       last;
  } hdr_beat_t;

  class header_scoreboard;
    logic [ihb_pkg::ADDR_W-1:0] local_addr;
    logic [ihb_pkg::ADDR_W-1:0] mask;
    logic [ihb_pkg::ADDR_W-1:0] gateway;
    hdr_beat_t                  pending_words[$];
    int                         mismatches;

    function new();
      local_addr = '0;
      mask       = '0;
      gateway    = '0;
      mismatches = 0;
    endfunction

    function void write_reg(logic [ihb_pkg::CFG_IDX_W-1:0] idx,
                            logic [ihb_pkg::ADDR_W-1:0] data);
      case (idx)
        ihb_pkg::REG_LOCAL_ADDR: local_addr = data;
        ihb_pkg::REG_SUBNET:     mask = data;
        ihb_pkg::REG_GATEWAY:    gateway = data;
        default: ;
      endcase
    endfunction

    function int pending();
      return pending_words.size();
    endfunction

    // Builds the header beats of one accepted request
    function void note_request(logic [ihb_pkg::ADDR_W-1:0] src,
                               logic [ihb_pkg::ADDR_W-1:0] dst,
                               logic [ihb_pkg::PROTO_W-1:0] proto,
                               logic [ihb_pkg::WORD_W-1:0] plen);
      logic [ihb_pkg::WORD_W-1:0] w [0:ihb_pkg::HDR_WORDS-1];
      logic [ihb_pkg::ADDR_W-1:0] hop;
      logic                       bcast;
      logic [31:0]                acc;
      hdr_beat_t                  b;
      b = '0;
      if (plen > ihb_pkg::MAX_PAYLOAD) begin
        b.too_long = 1'b1;
        b.last     = 1'b1;
        pending_words.push_back(b);
        return;
      end
      w[0] = {ihb_pkg::VER_IHL, 8'h00};
      w[1] = ihb_pkg::WORD_W'(ihb_pkg::HDR_BYTES) + plen;
      w[2] = '0;
      w[3] = '0;
      w[4] = {ihb_pkg::TTL_VALUE, proto};
      w[5] = '0;
      w[6] = src[31:16];
      w[7] = src[15:0];
      w[8] = dst[31:16];
      w[9] = dst[15:0];
      acc = '0;
      for (int k = 0; k < ihb_pkg::HDR_WORDS; k++) acc += w[k];
      while (acc > 32'hFFFF) acc = acc[15:0] + acc[31:16];
      w[5] = ~acc[15:0];
      if (dst == ihb_pkg::BCAST_ADDR) begin
        bcast = 1'b1;
        hop   = '0;
      end else begin
        bcast = 1'b0;
        hop   = ((dst & mask) == (local_addr & mask)) ? dst : gateway;
      end
      for (int k = 0; k < ihb_pkg::HDR_WORDS; k++) begin
        b.word     = w[k];
        b.index    = ihb_pkg::IDX_W'(k);
        b.hop      = hop;
        b.bcast    = bcast;
        b.too_long = 1'b0;
        b.last     = (k == ihb_pkg::HDR_WORDS - 1);
        pending_words.push_back(b);
      end
    endfunction

    task report_mismatch(string what);
      $display("MISMATCH at %0t: %s", $realtime, what);
      mismatches++;
    endtask

    task check_beat(hdr_beat_t got);
      hdr_beat_t exp;
      if (pending_words.size() == 0) begin
        report_mismatch($sformatf("beat with nothing expected: word %h index %0d",
                                  got.word, got.index));
        return;
      end
      exp = pending_words.pop_front();
      if (got.word !== exp.word)
        report_mismatch($sformatf("header_word at index %0d: got %h, want %h",
                                  exp.index, got.word, exp.word));
      if (got.index !== exp.index)
        report_mismatch($sformatf("word_index: got %0d, want %0d", got.index, exp.index));
      if (got.hop !== exp.hop)
        report_mismatch($sformatf("next_hop at index %0d: got %h, want %h",
                                  exp.index, got.hop, exp.hop));
      if (got.bcast !== exp.bcast)
        report_mismatch($sformatf("is_broadcast at index %0d: got %b, want %b",
                                  exp.index, got.bcast, exp.bcast));
      if (got.too_long !== exp.too_long)
        report_mismatch($sformatf("too_long at index %0d: got %b, want %b",
                                  exp.index, got.too_long, exp.too_long));
      if (got.last !== exp.last)
        report_mismatch($sformatf("last_word at index %0d: got %b, want %b",
                                  exp.index, got.last, exp.last));
    endtask
  endclass

  logic                          clk_i = 1'b0;
  logic                          rst_ni;
  logic                          cfg_we_i;
  logic [ihb_pkg::CFG_IDX_W-1:0] cfg_index_i;
  logic [ihb_pkg::ADDR_W-1:0]    cfg_data_i;
  logic                          in_valid_i;
  logic                          in_ready_o;
  logic [ihb_pkg::ADDR_W-1:0]    source_address_i;
  logic [ihb_pkg::ADDR_W-1:0]    destination_address_i;
  logic [ihb_pkg::PROTO_W-1:0]   protocol_number_i;
  logic [ihb_pkg::WORD_W-1:0]    payload_length_i;
  logic                          out_valid_o;
  logic                          out_ready_i;
  logic [ihb_pkg::WORD_W-1:0]    header_word_o;
  logic [ihb_pkg::IDX_W-1:0]     word_index_o;
  logic [ihb_pkg::ADDR_W-1:0]    next_hop_o;
  logic                          is_broadcast_o;
  logic                          too_long_o;
  logic                          last_word_o;

  header_scoreboard hdr_sb = new();
  int send_idle_pct   = 0;
  int ready_stall_pct = 0;
  int hold_len        = 0;

  ipv4_header_builder uut (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .cfg_we_i              (cfg_we_i),
    .cfg_index_i           (cfg_index_i),
    .cfg_data_i            (cfg_data_i),
    .in_valid_i            (in_valid_i),
    .in_ready_o            (in_ready_o),
    .source_address_i      (source_address_i),
    .destination_address_i (destination_address_i),
    .protocol_number_i     (protocol_number_i),
    .payload_length_i      (payload_length_i),
    .out_valid_o           (out_valid_o),
    .out_ready_i           (out_ready_i),
    .header_word_o         (header_word_o),
    .word_index_o          (word_index_o),
    .next_hop_o            (next_hop_o),
    .is_broadcast_o        (is_broadcast_o),
    .too_long_o            (too_long_o),
    .last_word_o           (last_word_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Offers one request, with random idle cycles ahead of it, and waits until it is accepted
  task send_request(logic [ihb_pkg::ADDR_W-1:0] src, logic [ihb_pkg::ADDR_W-1:0] dst,
                    logic [ihb_pkg::PROTO_W-1:0] proto, logic [ihb_pkg::WORD_W-1:0] plen);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i            <= 1'b1;
    source_address_i      <= src;
    destination_address_i <= dst;
    protocol_number_i     <= proto;
    payload_length_i      <= plen;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    hdr_sb.note_request(src, dst, proto, plen);
  endtask

  task send_random(int count);
    logic [ihb_pkg::WORD_W-1:0] plen;
    logic [ihb_pkg::ADDR_W-1:0] dst;
    int                         pick;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      if (pick < 15)
        plen = ihb_pkg::WORD_W'($urandom_range(ihb_pkg::MAX_PAYLOAD + 1, 16'hFFFF));
      else if (pick < 20)
        plen = (pick < 17) ? '0 : ihb_pkg::WORD_W'(ihb_pkg::MAX_PAYLOAD);
      else
        plen = ihb_pkg::WORD_W'($urandom_range(0, ihb_pkg::MAX_PAYLOAD));
      pick = $urandom_range(99);
      if (pick < 8) dst = ihb_pkg::BCAST_ADDR;
      else if (pick < 50) dst = (hdr_sb.local_addr & hdr_sb.mask) | ($urandom & ~hdr_sb.mask);
      else dst = $urandom;
      send_request($urandom, dst, ihb_pkg::PROTO_W'($urandom_range(0, 255)), plen);
    end
  endtask

  // Sender pause: nothing new until every expected beat is back
  task wait_drained();
    in_valid_i <= 1'b0;
    while (hdr_sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task cfg_write(logic [ihb_pkg::CFG_IDX_W-1:0] idx, logic [ihb_pkg::ADDR_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    hdr_sb.write_reg(idx, data);
  endtask

  task set_routing(logic [ihb_pkg::ADDR_W-1:0] local_addr, logic [ihb_pkg::ADDR_W-1:0] mask,
                   logic [ihb_pkg::ADDR_W-1:0] gateway, bit with_unmapped);
    if (with_unmapped) cfg_write(REG_UNMAPPED, $urandom);
    cfg_write(ihb_pkg::REG_LOCAL_ADDR, local_addr);
    cfg_write(ihb_pkg::REG_SUBNET, mask);
    cfg_write(ihb_pkg::REG_GATEWAY, gateway);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Receiver: checks accepted beats, stalls at random or for a counted hold-off
  initial begin
    hdr_beat_t got;
    out_ready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) begin
        got = {header_word_o, word_index_o, next_hop_o, is_broadcast_o, too_long_o,
               last_word_o};
        hdr_sb.check_beat(got);
      end
      if (hold_len > 0) begin
        out_ready_i <= 1'b0;
        hold_len--;
      end else begin
        out_ready_i <= ($urandom_range(99) >= ready_stall_pct);
      end
    end
  end

  initial begin
    rst_ni                <= 1'b0;
    cfg_we_i              <= 1'b0;
    cfg_index_i           <= ihb_pkg::REG_LOCAL_ADDR;
    cfg_data_i            <= '0;
    in_valid_i            <= 1'b0;
    source_address_i      <= '0;
    destination_address_i <= '0;
    protocol_number_i     <= '0;
    payload_length_i      <= '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Registers at reset: zero mask, every non-broadcast destination is its own next hop
    send_random(50);
    wait_drained();

    set_routing(32'hC0A8_010A, 32'hFFFF_FF00, 32'hC0A8_0101, 1'b0);
    send_request(32'h0000_0000, 32'h0000_0000, 8'h00, 16'd0);
    send_request(32'hFFFF_FFFF, ihb_pkg::BCAST_ADDR, 8'hFF,
                 ihb_pkg::WORD_W'(ihb_pkg::MAX_PAYLOAD));
    send_request(32'hC0A8_010A, 32'hC0A8_0105, 8'h06,
                 ihb_pkg::WORD_W'(ihb_pkg::MAX_PAYLOAD + 1));
    send_request(32'hC0A8_010A, 32'hC0A8_01FF, 8'h11, 16'hFFFF);
    send_request(32'h0A00_0001, 32'hC0A8_010A, 8'h01,
                 ihb_pkg::WORD_W'(ihb_pkg::MAX_PAYLOAD - 1));
    send_request(32'hC0A8_0177, 32'h0808_0808, 8'h11, 16'd100);
    send_request(32'hFFFF_0000, 32'h0000_FFFF, 8'h80, 16'h0400);
    send_request(32'h1234_5678, 32'hFFFF_FFFE, 8'h55, 16'd1);
    send_request(32'hFFFF_FFFF, 32'hC0A8_0100, 8'hAA, 16'd65515);
    send_request(32'h0000_0000, ihb_pkg::BCAST_ADDR, 8'h00,
                 ihb_pkg::WORD_W'(ihb_pkg::MAX_PAYLOAD + 1));
    // heavy end-around carry in the checksum
    send_request(32'hFFFF_FFFF, 32'hFFFF_FFFE, 8'hFF,
                 ihb_pkg::WORD_W'(ihb_pkg::MAX_PAYLOAD));
    send_request(32'h7FFF_8000, 32'h8000_7FFF, 8'h7F, 16'h02AA);
    send_request(32'hC0A8_01FE, 32'hC0A9_0101, 8'h32, 16'h0155);

    send_idle_pct = 56;
    send_random(82);
    wait_drained();

    set_routing($urandom, 32'hFFFF_FFFF, $urandom, 1'b0);
    send_idle_pct   = 0;
    ready_stall_pct = 56;
    send_random(82);
    wait_drained();

    set_routing(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    send_idle_pct   = 37;
    ready_stall_pct = 37;
    send_random(82);
    wait_drained();

    // Long receiver hold-off while requests keep coming: queue fills, input stalls
    set_routing($urandom, ~(32'hFFFF_FFFF >> $urandom_range(1, 31)), $urandom, 1'b0);
    send_idle_pct   = 0;
    ready_stall_pct = 0;
    hold_len        = 300;
    send_random(82);
    wait_drained();

    set_routing($urandom, 32'h0000_0000, 32'h0000_0000, 1'b1);
    ready_stall_pct = 56;
    send_random(82);
    wait_drained();

    repeat (20) @(posedge clk_i);
    if (hdr_sb.mismatches == 0) begin
      $display("ipv4_header_builder verification clean");
    end else begin
      $display("ipv4_header_builder verification failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("ipv4_header_builder verification failed");
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/ihb_pkg.sv
hw/rtl/ihb_front.sv
hw/rtl/ihb_queue.sv
hw/rtl/ihb_back.sv
hw/rtl/ipv4_header_builder.sv
test/ipv4_header_builder_tb.sv
